FILE: rtl/core/iobdl_pkg.sv
// Shared types and constants for the insulin-on-board dose log.
// Depends on nothing; every module of the block imports it.
package iobdl_pkg;

    // Number of dose records kept in the log.
    localparam int LOG_DEPTH = 16;
    localparam int SLOT_W = $clog2(LOG_DEPTH);

    // Field widths.
    localparam int TIME_W = 32;
    localparam int DOSE_W = 16;
    localparam int SPAN_W = 32;
    localparam int ACT_W = 10;

    // Longest action time is 1023 minutes of 60000 ms.
    localparam int DIA_W = $clog2(1023 * 60000 + 1);
    localparam logic [15:0] MS_PER_MIN = 16'd60000;
    localparam logic [ACT_W-1:0] ACTION_RESET = ACT_W'(300);

    // Insulin accumulator saturates at 2^48.
    localparam int ACC_W = 49;
    localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {(ACC_W-1){1'b0}}};

    // Fraction is Q0.16 with 1.0 as 65536, so it needs 17 bits.
    localparam int FRAC_W = 17;
    localparam int Q_W = 16;
    localparam int SUM_W = 26;

    // Shared divider sizes.
    localparam int NUM_W = 58;
    localparam int DEN_W = 32;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        OP_BOLUS      = 2'd0,
        OP_EXT_START  = 2'd1,
        OP_EXT_CANCEL = 2'd2,
        OP_RECOMPUTE  = 2'd3
    } op_t;

    // One dose record as stored in the log memory.
    typedef struct packed {
        logic              ext;
        logic [TIME_W-1:0] start;
        logic [DOSE_W-1:0] dose;
        logic [SPAN_W-1:0] span;
    } slot_rec_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] rem_init;
        logic [NUM_W-1:0] bits;
        logic [CNT_W-1:0] count;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_WRITE,
        ST_CAN_CHK,
        ST_RC_RD,
        ST_RC_CHK,
        ST_F_START,
        ST_F_WAIT,
        ST_F_SQ,
        ST_F_USE,
        ST_BOL_ADD,
        ST_EXT_LOOP,
        ST_EXT_MUL,
        ST_EXT_DIV,
        ST_EXT_WAIT,
        ST_FIN
    } state_t;

endpackage

FILE: rtl/core/iobdl_ram.sv
// Dose record memory: one write port, one read port, registered read data.
// Depends on iobdl_pkg for the record type and depth.
module iobdl_ram (
    input  logic                  clk,
    input  logic                  we,
    input  iobdl_pkg::slot_idx_t  waddr,
    input  iobdl_pkg::slot_rec_t  wdata,
    input  iobdl_pkg::slot_idx_t  raddr,
    output iobdl_pkg::slot_rec_t  rdata
);
    import iobdl_pkg::*;

    slot_rec_t mem [LOG_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/iobdl_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on iobdl_pkg for the request struct and widths.
module iobdl_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  iobdl_pkg::div_req_t          req,
    output logic                         busy,
    output logic                         done,
    output logic [iobdl_pkg::NUM_W-1:0]  quotient
);
    import iobdl_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] bits_reg, bits_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_sh = {rem_reg, bits_reg[NUM_W-1]};
        ge = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        bits_next = bits_reg;
        quo_next = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = req.count;
            rem_next = req.rem_init;
            den_next = req.den;
            bits_next = req.bits;
            quo_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            bits_next = {bits_reg[NUM_W-2:0], 1'b0};
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        bits_reg <= bits_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/insulin_on_board_dose_log_top.sv
// Top level of the insulin-on-board dose log: command sequencer and datapath.
// Depends on iobdl_pkg, iobdl_ram (record memory) and iobdl_div (divider).
//
// Usage:
// Commands enter on the in_valid/in_ready channel with opcode, time_ms,
// dose_hundredths and span_ms. Only a recompute command yields a result,
// which leaves on out_valid/out_ready as iob_ten_thousandths. The action
// time is written through cfg_wr_en/cfg_wr_data while the block is idle.
// The block works on one command at a time; in_ready is high only when idle.
// A bolus or extended start writes a free slot directly, or overwrites the
// oldest record, found by scanning the memory, when the log is full. A
// recompute walks every slot; each live bolus record takes at most one
// division for its remaining fraction, and each live extended record at most
// one per minute term plus a final division, all on the shared
// one-bit-a-cycle divider. A finished result sits in an output register;
// if the receiver stalls, the next recompute waits at its end for the
// register to drain, and no other command is taken meanwhile. Reset clears
// all valid marks and the active extended marker and loads an action time
// of 300 minutes; the record memory needs no clearing pass.
module insulin_on_board_dose_log_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [iobdl_pkg::ACT_W-1:0]    cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [iobdl_pkg::TIME_W-1:0]   time_ms,
    input  logic [iobdl_pkg::DOSE_W-1:0]   dose_hundredths,
    input  logic [iobdl_pkg::SPAN_W-1:0]   span_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [31:0]                    iob_ten_thousandths
);
    import iobdl_pkg::*;

    localparam slot_idx_t LAST_SLOT = SLOT_W'(LOG_DEPTH - 1);

    state_t            state_reg, state_next;
    logic [ACT_W-1:0]  action_reg;
    op_t               op_reg;
    logic [TIME_W-1:0] time_reg;
    logic [DOSE_W-1:0] dose_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [DIA_W-1:0]  dia_reg;
    slot_idx_t         idx_reg;
    slot_idx_t         slot_reg;
    slot_idx_t         best_reg;
    logic [TIME_W-1:0] best_t_reg;
    logic [LOG_DEPTH-1:0] valid_reg;
    logic              active_none_reg;
    slot_idx_t         active_idx_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              ext_reg;
    logic [DOSE_W-1:0] rdose_reg;
    logic [SPAN_W-1:0] rspan_reg;
    logic [DIA_W-1:0]  el_reg;
    logic [DIA_W-1:0]  end_reg;
    logic [DIA_W:0]    off_reg;
    logic [DIA_W-1:0]  age_reg;
    logic              fbr_reg;
    logic [31:0]       sq_reg;
    logic [FRAC_W-1:0] f_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [31:0]       dm_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  prod_reg;
    logic              out_valid_reg;
    logic [31:0]       out_reg;

    logic              in_xfer;
    op_t               op_in;
    logic              any_free;
    slot_idx_t         free_idx;
    logic              mem_we;
    slot_idx_t         mem_waddr;
    slot_rec_t         mem_wdata;
    slot_idx_t         mem_raddr;
    slot_rec_t         mem_rdata;
    div_req_t          div_req;
    logic              div_busy;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;
    logic [TIME_W-1:0] el_rd;
    logic              expired;
    logic              scan_lt;
    slot_idx_t         scan_best;
    logic              last_slot;
    logic              out_free;
    logic [FRAC_W-1:0] f_rnd;
    logic [55:0]       scaled;
    logic [39:0]       rounded;
    logic [31:0]       result;

    assign op_in = op_t'(opcode);
    assign in_xfer = in_valid && in_ready;
    assign last_slot = (idx_reg == LAST_SLOT);
    assign out_free = !out_valid_reg || out_ready;

    // Saturating accumulate into the insulin sum.
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [NUM_W-1:0] b);
        logic [NUM_W:0] s;
        s = (NUM_W+1)'(a) + (NUM_W+1)'(b);
        return (s > (NUM_W+1)'(ACC_CAP)) ? ACC_CAP : ACC_W'(s);
    endfunction

    // Lowest free slot from the valid marks.
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = LOG_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // Elapsed time of the record just read, and its expiry test.
    assign el_rd = (time_reg > mem_rdata.start) ? (time_reg - mem_rdata.start) : '0;
    assign expired = (el_rd > TIME_W'(dia_reg));

    // Oldest record search during a full-log scan.
    assign scan_lt = (mem_rdata.start < best_t_reg);
    assign scan_best = scan_lt ? idx_reg : best_reg;

    // Remaining fraction from the squared quotient, rounded half up.
    assign f_rnd = FRAC_W'(({1'b0, sq_reg, 1'b0} + 34'd32768) >> 16);

    // Final scaling to 1/10000 unit with saturation.
    assign scaled = 56'(acc_reg) * 56'd100;
    assign rounded = 40'((scaled + 56'd32768) >> 16);
    assign result = (|rounded[39:32]) ? 32'hFFFF_FFFF : rounded[31:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_in)
                        OP_BOLUS, OP_EXT_START:
                        begin
                            if (dose_hundredths == '0 ||
                                (op_in == OP_EXT_START && span_ms == '0))
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (any_free)
                            begin
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        OP_EXT_CANCEL:
                        begin
                            if (!active_none_reg && valid_reg[active_idx_reg])
                            begin
                                state_next = ST_CAN_CHK;
                            end
                        end
                        OP_RECOMPUTE:
                        begin
                            state_next = ST_RC_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                state_next = last_slot ? ST_WRITE : ST_SCAN_RD;
            end
            ST_WRITE, ST_CAN_CHK:
            begin
                state_next = ST_IDLE;
            end
            ST_RC_RD:
            begin
                if (valid_reg[idx_reg])
                begin
                    state_next = ST_RC_CHK;
                end
                else if (last_slot)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RC_CHK:
            begin
                if (!expired && !mem_rdata.ext)
                begin
                    state_next = ST_F_START;
                end
                else if (!expired && mem_rdata.dose != '0 && mem_rdata.span != '0)
                begin
                    state_next = ST_EXT_LOOP;
                end
                else
                begin
                    state_next = last_slot ? ST_FIN : ST_RC_RD;
                end
            end
            ST_F_START:
            begin
                state_next = (age_reg >= dia_reg) ? ST_F_USE : ST_F_WAIT;
            end
            ST_F_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_F_SQ;
                end
            end
            ST_F_SQ:
            begin
                state_next = ST_F_USE;
            end
            ST_F_USE:
            begin
                state_next = ext_reg ? ST_EXT_LOOP : ST_BOL_ADD;
            end
            ST_BOL_ADD:
            begin
                state_next = last_slot ? ST_FIN : ST_RC_RD;
            end
            ST_EXT_LOOP:
            begin
                state_next = (off_reg < (DIA_W+1)'(end_reg)) ? ST_F_START : ST_EXT_MUL;
            end
            ST_EXT_MUL:
            begin
                state_next = ST_EXT_DIV;
            end
            ST_EXT_DIV:
            begin
                state_next = ST_EXT_WAIT;
            end
            ST_EXT_WAIT:
            begin
                if (div_done)
                begin
                    state_next = last_slot ? ST_FIN : ST_RC_RD;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake, memory ports and divider requests.
    always_comb
    begin
        in_ready = 1'b0;
        mem_we = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = mem_rdata;
        mem_raddr = idx_reg;
        div_req = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                mem_raddr = active_idx_reg;
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                mem_wdata.ext = (op_reg == OP_EXT_START);
                mem_wdata.start = time_reg;
                mem_wdata.dose = dose_reg;
                mem_wdata.span = (op_reg == OP_EXT_START) ? span_reg : '0;
            end
            ST_CAN_CHK:
            begin
                mem_we = mem_rdata.ext;
                mem_wdata.dose = dose_reg;
                mem_wdata.span = (el_rd < mem_rdata.span) ? el_rd : mem_rdata.span;
            end
            ST_F_START:
            begin
                div_req.start = (age_reg < dia_reg);
                div_req.rem_init = ({1'b0, age_reg, 1'b0} <= (DIA_W+2)'(dia_reg)) ?
                                   DEN_W'(age_reg) : DEN_W'(dia_reg - age_reg);
                div_req.bits = '0;
                div_req.count = CNT_W'(Q_W);
                div_req.den = DEN_W'(dia_reg);
            end
            ST_EXT_DIV:
            begin
                div_req.start = 1'b1;
                div_req.rem_init = '0;
                div_req.bits = num_reg;
                div_req.count = CNT_W'(NUM_W);
                div_req.den = rspan_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            action_reg <= ACTION_RESET;
            valid_reg <= '0;
            active_none_reg <= 1'b1;
            active_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                action_reg <= cfg_wr_data;
            end
            if (state_reg == ST_IDLE && in_xfer && op_in == OP_EXT_CANCEL)
            begin
                active_none_reg <= 1'b1;
            end
            if (state_reg == ST_WRITE)
            begin
                valid_reg[slot_reg] <= 1'b1;
                if (op_reg == OP_EXT_START)
                begin
                    active_idx_reg <= slot_reg;
                    active_none_reg <= 1'b0;
                end
            end
            if (state_reg == ST_RC_CHK && expired)
            begin
                valid_reg[idx_reg] <= 1'b0;
                if (active_idx_reg == idx_reg)
                begin
                    active_none_reg <= 1'b1;
                end
            end
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg <= op_in;
                time_reg <= time_ms;
                dose_reg <= dose_hundredths;
                span_reg <= span_ms;
                dia_reg <= DIA_W'(action_reg * MS_PER_MIN);
                idx_reg <= '0;
                // A cancel targets the active record; a new record takes the lowest free slot, if any.
                slot_reg <= (any_free && op_in != OP_EXT_CANCEL) ? free_idx : active_idx_reg;
                best_reg <= '0;
                best_t_reg <= '1;
                acc_reg <= '0;
            end
            ST_SCAN_CHK:
            begin
                best_reg <= scan_best;
                if (scan_lt)
                begin
                    best_t_reg <= mem_rdata.start;
                end
                slot_reg <= scan_best;
                idx_reg <= idx_reg + 1'b1;
            end
            ST_RC_RD:
            begin
                if (!valid_reg[idx_reg])
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_RC_CHK:
            begin
                ext_reg <= mem_rdata.ext;
                rdose_reg <= mem_rdata.dose;
                rspan_reg <= mem_rdata.span;
                el_reg <= DIA_W'(el_rd);
                age_reg <= DIA_W'(el_rd);
                end_reg <= (el_rd < mem_rdata.span) ? DIA_W'(el_rd) : DIA_W'(mem_rdata.span);
                off_reg <= '0;
                sum_reg <= '0;
                if (state_next == ST_FIN || state_next == ST_RC_RD)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_F_START:
            begin
                fbr_reg <= ({1'b0, age_reg, 1'b0} <= (DIA_W+2)'(dia_reg));
                f_reg <= '0;
            end
            ST_F_WAIT:
            begin
                sq_reg <= 32'(div_quo[Q_W-1:0] * div_quo[Q_W-1:0]);
            end
            ST_F_SQ:
            begin
                f_reg <= fbr_reg ? FRAC_W'(18'd65536 - 18'(f_rnd)) : f_rnd;
            end
            ST_F_USE:
            begin
                prod_reg <= NUM_W'(rdose_reg * f_reg);
                sum_reg <= sum_reg + SUM_W'(f_reg);
                off_reg <= off_reg + (DIA_W+1)'(MS_PER_MIN);
            end
            ST_BOL_ADD:
            begin
                acc_reg <= sat_add(acc_reg, prod_reg);
                idx_reg <= idx_reg + 1'b1;
            end
            ST_EXT_LOOP:
            begin
                age_reg <= DIA_W'((DIA_W+1)'(el_reg) - off_reg);
                dm_reg <= 32'(rdose_reg * MS_PER_MIN);
            end
            ST_EXT_MUL:
            begin
                num_reg <= NUM_W'(dm_reg * sum_reg);
            end
            ST_EXT_WAIT:
            begin
                if (div_done)
                begin
                    acc_reg <= sat_add(acc_reg, div_quo);
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_reg <= result;
                end
            end
            default:
            begin
                f_reg <= f_reg;
            end
        endcase
    end

    iobdl_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    iobdl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid = out_valid_reg;
    assign iob_ten_thousandths = out_reg;

    // The divider is never left running when a new command may enter.
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !div_busy)
        else $error("divider busy while idle");

    // The active extended marker always points at a live record.
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_none_reg |-> valid_reg[active_idx_reg])
        else $error("active marker on an empty slot");

    // A result only appears at the end of a recompute.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside recompute");

endmodule

FILE: test/insulin_on_board_dose_log_top_test.sv
// Self-checking testbench for the insulin-on-board dose log.
// Depends on iobdl_pkg and insulin_on_board_dose_log_top; it predicts every
// recompute answer with its own fixed-point Walsh model and checks it.
`timescale 1ns / 1ps

module insulin_on_board_dose_log_top_test;
    import iobdl_pkg::*;

    localparam int CYCLE_LIMIT = 40000000;
    localparam int DRAIN_CYCLES = 200;
    localparam longint unsigned MIN_MS = 60000;
    localparam longint unsigned IOB_CAP = 64'h1_0000_0000_0000;

    typedef struct {
        op_t         op;
        logic [31:0] t;
        logic [15:0] dose;
        logic [31:0] span;
    } dose_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [9:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [31:0] time_ms = '0;
    logic [15:0] dose_hundredths = '0;
    logic [31:0] span_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] iob_ten_thousandths;

    insulin_on_board_dose_log_top i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .opcode              (opcode),
        .time_ms             (time_ms),
        .dose_hundredths     (dose_hundredths),
        .span_ms             (span_ms),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .iob_ten_thousandths (iob_ten_thousandths)
    );

    always #4 clk = ~clk;

    // Commands waiting to be sent and IOB answers waiting to arrive.
    dose_cmd_t   pending_cmds[$];
    logic [31:0] iob_expected[$];

    // Shadow copy of the dose log.
    logic [9:0]  shadow_action;
    logic        shadow_valid[LOG_DEPTH];
    logic        shadow_ext[LOG_DEPTH];
    logic [31:0] shadow_start[LOG_DEPTH];
    logic [15:0] shadow_dose[LOG_DEPTH];
    logic [31:0] shadow_span[LOG_DEPTH];
    int          shadow_active;

    int mismatches = 0;
    int cmds_sent = 0;
    int iob_checked = 0;
    int cfg_writes = 0;
    int cycle_count = 0;
    logic calm = 1'b0;
    logic long_hold_req = 1'b0;
    logic long_hold_seen = 1'b0;
    int hold_left = 0;

    // Remaining Walsh fraction in Q0.16.
    function automatic longint unsigned walsh_remaining(longint unsigned age,
                                                        longint unsigned dia);
        longint unsigned q;
        if (age >= dia)
            return 0;
        if (2 * age <= dia)
        begin
            q = (age << 16) / dia;
            return 65536 - ((2 * q * q + 32768) >> 16);
        end
        q = ((dia - age) << 16) / dia;
        return (2 * q * q + 32768) >> 16;
    endfunction

    function automatic longint unsigned elapsed_ms(logic [31:0] now, logic [31:0] start);
        return (now > start) ? longint'(now - start) : 0;
    endfunction

    // First free slot, else the one with the oldest start.
    function automatic int free_or_oldest_slot();
        int best;
        logic [31:0] best_t;
        best = 0;
        best_t = 32'hFFFF_FFFF;
        for (int i = 0; i < LOG_DEPTH; i++)
            if (!shadow_valid[i])
                return i;
        for (int i = 0; i < LOG_DEPTH; i++)
            if (shadow_start[i] < best_t)
            begin
                best_t = shadow_start[i];
                best = i;
            end
        return best;
    endfunction

    // Sums insulin on board at a given time, expiring old records on the way.
    function automatic logic [31:0] iob_at(logic [31:0] now);
        longint unsigned acc, dia, el, fin, sum, term, res;
        acc = 0;
        dia = longint'(shadow_action) * MIN_MS;
        for (int i = 0; i < LOG_DEPTH; i++)
        begin
            if (!shadow_valid[i])
                continue;
            el = elapsed_ms(now, shadow_start[i]);
            if (el > dia)
            begin
                shadow_valid[i] = 1'b0;
                if (shadow_active == i)
                    shadow_active = LOG_DEPTH;
                continue;
            end
            term = 0;
            if (!shadow_ext[i])
                term = longint'(shadow_dose[i]) * walsh_remaining(el, dia);
            else if (shadow_dose[i] != 0 && shadow_span[i] != 0)
            begin
                fin = (el < shadow_span[i]) ? el : longint'(shadow_span[i]);
                sum = 0;
                for (longint unsigned off = 0; off < fin; off += MIN_MS)
                    sum += walsh_remaining(el - off, dia);
                term = (longint'(shadow_dose[i]) * MIN_MS * sum) / shadow_span[i];
            end
            acc = acc + term;
            if (acc > IOB_CAP)
                acc = IOB_CAP;
        end
        res = (acc * 100 + 32768) >> 16;
        return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
    endfunction

    // Applies one accepted command to the shadow log.
    task automatic apply_cmd(input dose_cmd_t c);
        int s;
        longint unsigned el;
        case (c.op)
            OP_BOLUS:
                if (c.dose != 0)
                begin
                    s = free_or_oldest_slot();
                    shadow_valid[s] = 1'b1;
                    shadow_ext[s] = 1'b0;
                    shadow_start[s] = c.t;
                    shadow_dose[s] = c.dose;
                    shadow_span[s] = '0;
                end
            OP_EXT_START:
                if (c.dose != 0 && c.span != 0)
                begin
                    s = free_or_oldest_slot();
                    shadow_valid[s] = 1'b1;
                    shadow_ext[s] = 1'b1;
                    shadow_start[s] = c.t;
                    shadow_dose[s] = c.dose;
                    shadow_span[s] = c.span;
                    shadow_active = s;
                end
            OP_EXT_CANCEL:
                if (shadow_active < LOG_DEPTH)
                begin
                    s = shadow_active;
                    shadow_active = LOG_DEPTH;
                    if (shadow_valid[s] && shadow_ext[s])
                    begin
                        el = elapsed_ms(c.t, shadow_start[s]);
                        if (el > shadow_span[s])
                            el = shadow_span[s];
                        shadow_span[s] = el[31:0];
                        shadow_dose[s] = c.dose;
                    end
                end
            default:
                iob_expected.push_back(iob_at(c.t));
        endcase
    endtask

    // Command driver: presents queued commands with random idle bursts.
    dose_cmd_t cur_cmd;
    int tx_gap = 0;
    always @(posedge clk)
    begin
        logic next_valid;
        next_valid = in_valid;
        if (in_valid && in_ready)
        begin
            apply_cmd(cur_cmd);
            cmds_sent++;
        end
        if (!in_valid || in_ready)
        begin
            next_valid = 1'b0;
            if (tx_gap > 0)
                tx_gap--;
            else if (pending_cmds.size() != 0)
            begin
                if (!calm && $urandom_range(0, 7) == 0)
                    tx_gap = $urandom_range(1, 12) - 1;
                else
                begin
                    cur_cmd = pending_cmds.pop_front();
                    opcode <= cur_cmd.op;
                    time_ms <= cur_cmd.t;
                    dose_hundredths <= cur_cmd.dose;
                    span_ms <= cur_cmd.span;
                    next_valid = 1'b1;
                end
            end
        end
        in_valid <= next_valid;
    end

    // Long receiver hold-off, counted on its own.
    always @(posedge clk)
    begin
        if (long_hold_req && !long_hold_seen)
        begin
            hold_left <= 1500;
            long_hold_seen <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor: checks each transfer against the oldest expectation.
    int rx_gap = 0;
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (out_valid && out_ready)
        begin
            if (iob_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected IOB result %0d", iob_ten_thousandths);
            end
            else
            begin
                want = iob_expected.pop_front();
                iob_checked++;
                if (want !== iob_ten_thousandths)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("IOB mismatch: expected %0d, got %0d",
                                 want, iob_ten_thousandths);
                end
            end
        end
        if (hold_left != 0)
            out_ready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            rx_gap = $urandom_range(1, 12) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL insulin_on_board_dose_log_top");
            $finish;
        end
    end

    function automatic dose_cmd_t mk(op_t op, logic [31:0] t, logic [15:0] d,
                                     logic [31:0] s);
        dose_cmd_t c;
        c.op = op;
        c.t = t;
        c.dose = d;
        c.span = s;
        return c;
    endfunction

    // Waits until every command is sent and answered, then lets the block settle.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || iob_expected.size() != 0
               || tx_gap != 0);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_action(input logic [9:0] minutes);
        wait_quiet();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= minutes;
        shadow_action = minutes;
        cfg_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Random commands around a moving clock, mostly plausible dosing.
    task automatic queue_random(input int n, inout logic [31:0] now);
        dose_cmd_t c;
        int pick;
        for (int k = 0; k < n; k++)
        begin
            now = now + $urandom_range(0, 180000);
            pick = $urandom_range(0, 99);
            c.op = op_t'((pick < 40) ? OP_BOLUS : (pick < 60) ? OP_EXT_START :
                         (pick < 70) ? OP_EXT_CANCEL : OP_RECOMPUTE);
            c.t = ($urandom_range(0, 99) < 4) ? $urandom() : now;
            if (c.op == OP_EXT_START && $urandom_range(0, 1) == 1)
                c.t = now - $urandom_range(0, 60000);
            c.dose = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            pick = $urandom_range(0, 99);
            c.span = (pick < 5) ? 32'd0 : (pick < 15) ? $urandom() :
                     32'($urandom_range(1, 300000));
            pending_cmds.push_back(c);
        end
    endtask

    initial
    begin
        logic [31:0] now;
        shadow_action = ACTION_RESET;
        for (int i = 0; i < LOG_DEPTH; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_ext[i] = 1'b0;
            shadow_start[i] = '0;
            shadow_dose[i] = '0;
            shadow_span[i] = '0;
        end
        shadow_active = LOG_DEPTH;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset action time: ignored commands, extremes,
        // cancel with and without an active extended dose, future starts.
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'd0, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_BOLUS, 32'd5, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_EXT_START, 32'd5, 16'd0, 32'd100));
        pending_cmds.push_back(mk(OP_EXT_START, 32'd5, 16'd5, 32'd0));
        pending_cmds.push_back(mk(OP_EXT_CANCEL, 32'd0, 16'd7, 32'd0));
        pending_cmds.push_back(mk(OP_BOLUS, 32'd0, 16'hFFFF, 32'd0));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'd0, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'd9000000, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_EXT_START, 32'd9000000, 16'hFFFF, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'd9180000, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_EXT_CANCEL, 32'd9240000, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'd9250000, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_EXT_START, 32'd9300000, 16'd1000, 32'd600000));
        pending_cmds.push_back(mk(OP_BOLUS, 32'hFFFF_FFFF, 16'd1, 32'd0));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'd9420000, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_EXT_CANCEL, 32'd9450000, 16'd123, 32'd0));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'd9500000, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'hFFFF_FFFF, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_EXT_CANCEL, 32'hFFFF_FFFF, 16'd9, 32'd0));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'hFFFF_FFFF, 16'd0, 32'd0));

        // Action time of zero: only a record started right now survives.
        write_action(10'd0);
        pending_cmds.push_back(mk(OP_BOLUS, 32'd1000, 16'd500, 32'd0));
        pending_cmds.push_back(mk(OP_EXT_START, 32'd1000, 16'd700, 32'd60000));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'd1000, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_RECOMPUTE, 32'd1001, 16'd0, 32'd0));
        pending_cmds.push_back(mk(OP_EXT_CANCEL, 32'd1002, 16'd1, 32'd0));

        // Action time of one hour.
        write_action(10'd60);
        now = $urandom();
        queue_random(30, now);

        // Action time of 720 minutes; the log fills up, and the receiver holds off
        // for a long stretch while recomputes keep coming.
        write_action(10'd720);
        now = $urandom();
        queue_random(25, now);
        for (int k = 0; k < 6; k++)
            pending_cmds.push_back(mk(OP_RECOMPUTE, now + k * 1000, 16'd0, 32'd0));
        long_hold_req <= 1'b1;

        // Random action time, no idling on either side.
        write_action(10'($urandom_range(60, 720)));
        calm = 1'b1;
        now = $urandom();
        queue_random(25, now);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (iob_expected.size() != 0)
            mismatches++;
        $display("Sent %0d dose commands over %0d action-time settings,",
                 cmds_sent, cfg_writes + 1);
        $display("checked %0d insulin-on-board answers, %0d mismatches.",
                 iob_checked, mismatches);
        if (mismatches == 0)
            $display("PASS insulin_on_board_dose_log_top");
        else
            $display("FAIL insulin_on_board_dose_log_top");
        $finish;
    end

endmodule

FILE: insulin_on_board_dose_log_top.f
rtl/core/iobdl_pkg.sv
rtl/core/iobdl_ram.sv
rtl/core/iobdl_div.sv
rtl/core/insulin_on_board_dose_log_top.sv
test/insulin_on_board_dose_log_top_test.sv
